/* rtl/srrs_pkg.sv */
`timescale 1ns / 1ps

package srrs_pkg;

    // rank and count widths fixed by the word formats
    localparam int RANK_W   = 5;
    localparam int SIZE_W   = 6;
    localparam int STATUS_W = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // status codes reported in the summary word
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_STEP = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SIGN      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd4;

    // result word kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // register index, taken from the word address bit
    localparam logic REG_GROUP_SIZE = 1'b0;
    localparam logic REG_MY_RANK    = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [RANK_W-1:0]   new_rank;
        logic [RANK_W-1:0]   old_rank;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   new_size;
        logic                my_included;
        logic [RANK_W-1:0]   my_new_rank;
        logic                last;
    } result_t;

endpackage

/* rtl/strided_range_rank_select.sv */
`timescale 1ns / 1ps

// Strided rank selection. Each input word carries a (first, last, stride) triplet of
// signed old ranks; the block walks the triplet and returns one entry word per selected
// rank, pairing it with a new rank that counts up from 0 over all triplets of one
// operation. The word flagged last_triplet additionally returns a summary word with the
// status, the new group size and where my_rank landed. The first error (rank out of
// range, zero stride, stride pointing away from last, duplicate rank) is sticky: later
// triplets of the operation return nothing until the summary. Timing: after a triplet is
// accepted, the walk handles one selected rank per cycle while the output is not stalled,
// bounded by the single read port of the taken-rank memory which is read one rank ahead;
// then the held-back final entry is released. A final triplet adds the summary word and
// then a clearing pass over all MAX_RANKS entries of the taken-rank memory; the same pass
// runs right after reset. No triplet is accepted during the pass, while register writes
// are taken at any time. The group_size register (offset 0x0) and the my_rank register
// (offset 0x4) are written and read over the APB port.
module strided_range_rank_select
    import srrs_pkg::*;
#(
    parameter int MAX_RANKS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,

    // triplet input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [7:0]        s_start_rank,
    input  logic signed [7:0]        s_stop_rank,
    input  logic signed [7:0]        s_stride,
    input  logic                     s_last_triplet,

    // result output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_kind,
    output logic [RANK_W-1:0]        m_new_rank,
    output logic [RANK_W-1:0]        m_old_rank,
    output logic [STATUS_W-1:0]      m_status,
    output logic [SIZE_W-1:0]        m_new_size,
    output logic                     m_my_included,
    output logic [RANK_W-1:0]        m_my_new_rank,
    output logic                     m_last
);

    localparam int IDX_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
    localparam logic [SIZE_W-1:0] MAX_EFF  = SIZE_W'(MAX_RANKS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_RANKS - 1);

    // sequencer states
    localparam logic [2:0] S_SWEEP   = 3'd0;  // clearing the taken-rank memory
    localparam logic [2:0] S_IDLE    = 3'd1;  // waiting for a triplet
    localparam logic [2:0] S_RUN     = 3'd2;  // taken bit of idx_reg is in rd_data_reg
    localparam logic [2:0] S_FLUSH   = 3'd3;  // release the held-back entry
    localparam logic [2:0] S_SUMMARY = 3'd4;  // emit the summary word

    // taken-rank memory, one bit per old rank, registered read
    logic                   taken_mem [MAX_RANKS];
    logic                   rd_data_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic                   wr_data;

    // configuration
    logic [SIZE_W-1:0]      group_size_reg;
    logic [RANK_W-1:0]      my_rank_reg;

    // sequencer and operation state
    logic [2:0]             state_reg, state_next;
    logic [IDX_W-1:0]       sweep_idx_reg, sweep_idx_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic signed [7:0]      end_rank_reg, end_rank_next;
    logic signed [7:0]      stride_reg, stride_next;
    logic                   single_reg, single_next;
    logic                   asc_reg, asc_next;
    logic                   fin_reg, fin_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [RANK_W-1:0]      pend_new_reg, pend_new_next;
    logic [IDX_W-1:0]       pend_old_reg, pend_old_next;
    logic [SIZE_W-1:0]      next_new_rank_reg, next_new_rank_next;
    logic [STATUS_W-1:0]    error_reg, error_next;
    logic                   my_seen_reg, my_seen_next;
    logic [RANK_W-1:0]      my_new_value_reg, my_new_value_next;

    // output stage
    logic                   m_valid_reg, m_valid_next;
    result_t                out_reg, out_next;
    logic                   slot_free;

    // triplet checks
    logic [SIZE_W-1:0]      eff_size;
    logic                   first_bad, last_bad, step_zero, sign_bad;
    logic                   s_accept;
    logic                   cfg_write;

    // walk arithmetic
    logic signed [9:0]      next_sum;
    logic                   walk_done;
    logic [7:0]             pend_old_wide;
    logic [7:0]             idx_wide;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // registers ---------------------------------------------------------

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= SIZE_W'(32);
            my_rank_reg    <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_GROUP_SIZE: group_size_reg <= pwdata[SIZE_W-1:0];
                REG_MY_RANK:    my_rank_reg    <= pwdata[RANK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GROUP_SIZE: prdata = APB_DW'(group_size_reg);
            REG_MY_RANK:    prdata = APB_DW'(my_rank_reg);
            default:        prdata = '0;
        endcase
    end

    // taken-rank memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            taken_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= taken_mem[rd_addr];
        end
    end

    // effective group size and checks on the incoming triplet
    assign eff_size  = (group_size_reg < MAX_EFF) ? group_size_reg : MAX_EFF;
    assign first_bad = s_start_rank[7] || (s_start_rank[6:0] >= {1'b0, eff_size});
    assign last_bad  = s_stop_rank[7]  || (s_stop_rank[6:0]  >= {1'b0, eff_size});
    assign step_zero = (s_stride == 8'sd0);
    assign sign_bad  = ((s_start_rank < s_stop_rank) && s_stride[7])
                    || ((s_start_rank > s_stop_rank) && !s_stride[7]);

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // next rank of the walk; ranks stay below 64, strides within a byte
    assign idx_wide  = 8'(idx_reg);
    assign next_sum  = $signed({2'b00, idx_wide}) + $signed({{2{stride_reg[7]}}, stride_reg});
    assign walk_done = single_reg
                    || (asc_reg  && (next_sum > $signed({{2{end_rank_reg[7]}}, end_rank_reg})))
                    || (!asc_reg && (next_sum < $signed({{2{end_rank_reg[7]}}, end_rank_reg})));
    assign pend_old_wide = 8'(pend_old_reg);

    always_comb begin
        state_next         = state_reg;
        sweep_idx_next     = sweep_idx_reg;
        idx_next           = idx_reg;
        end_rank_next      = end_rank_reg;
        stride_next        = stride_reg;
        single_next        = single_reg;
        asc_next           = asc_reg;
        fin_next           = fin_reg;
        pend_valid_next    = pend_valid_reg;
        pend_new_next      = pend_new_reg;
        pend_old_next      = pend_old_reg;
        next_new_rank_next = next_new_rank_reg;
        error_next         = error_reg;
        my_seen_next       = my_seen_reg;
        my_new_value_next  = my_new_value_reg;
        out_next           = out_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        rd_en              = 1'b0;
        rd_addr            = idx_reg;
        wr_en              = 1'b0;
        wr_addr            = idx_reg;
        wr_data            = 1'b1;

        unique case (state_reg)
            S_SWEEP: begin
                wr_en          = 1'b1;
                wr_addr        = sweep_idx_reg;
                wr_data        = 1'b0;
                sweep_idx_next = sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == LAST_IDX) begin
                    sweep_idx_next = '0;
                    state_next     = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_accept) begin
                    fin_next = s_last_triplet;
                    priority if (error_reg != ST_OK) begin
                        // sticky error: triplet is dropped
                        state_next = s_last_triplet ? S_SUMMARY : S_IDLE;
                    end else if (first_bad || last_bad) begin
                        error_next = ST_RANGE;
                        state_next = s_last_triplet ? S_SUMMARY : S_IDLE;
                    end else if (step_zero) begin
                        error_next = ST_ZERO_STEP;
                        state_next = s_last_triplet ? S_SUMMARY : S_IDLE;
                    end else if (sign_bad) begin
                        error_next = ST_SIGN;
                        state_next = s_last_triplet ? S_SUMMARY : S_IDLE;
                    end else begin
                        idx_next      = s_start_rank[IDX_W-1:0];
                        end_rank_next = s_stop_rank;
                        stride_next   = s_stride;
                        single_next   = (s_start_rank == s_stop_rank);
                        asc_next      = (s_start_rank < s_stop_rank);
                        rd_en         = 1'b1;
                        rd_addr       = s_start_rank[IDX_W-1:0];
                        state_next    = S_RUN;
                    end
                end
            end

            S_RUN: begin
                // an earlier entry is released once this rank is checked: here if it is good, else via S_FLUSH
                if (!pend_valid_reg || slot_free) begin
                    if (rd_data_reg) begin
                        error_next = ST_DUP;
                        priority if (pend_valid_reg) begin
                            state_next = S_FLUSH;
                        end else if (fin_reg) begin
                            state_next = S_SUMMARY;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        wr_data = 1'b1;
                        if (pend_valid_reg) begin
                            out_next      = '0;
                            out_next.kind = KIND_ENTRY;
                            out_next.new_rank = pend_new_reg;
                            out_next.old_rank = pend_old_wide[RANK_W-1:0];
                            m_valid_next  = 1'b1;
                        end
                        pend_valid_next    = 1'b1;
                        pend_new_next      = next_new_rank_reg[RANK_W-1:0];
                        pend_old_next      = idx_reg;
                        next_new_rank_next = next_new_rank_reg + 1'b1;
                        if (idx_wide == 8'(my_rank_reg)) begin
                            my_seen_next      = 1'b1;
                            my_new_value_next = next_new_rank_reg[RANK_W-1:0];
                        end
                        if (walk_done) begin
                            state_next = S_FLUSH;
                        end else begin
                            idx_next = next_sum[IDX_W-1:0];
                            rd_en    = 1'b1;
                            rd_addr  = next_sum[IDX_W-1:0];
                        end
                    end
                end
            end

            S_FLUSH: begin
                if (slot_free) begin
                    out_next          = '0;
                    out_next.kind     = KIND_ENTRY;
                    out_next.new_rank = pend_new_reg;
                    out_next.old_rank = pend_old_wide[RANK_W-1:0];
                    out_next.last     = !fin_reg;
                    m_valid_next      = 1'b1;
                    pend_valid_next   = 1'b0;
                    state_next        = fin_reg ? S_SUMMARY : S_IDLE;
                end
            end

            S_SUMMARY: begin
                if (slot_free) begin
                    out_next        = '0;
                    out_next.kind   = KIND_SUMMARY;
                    out_next.status = error_reg;
                    out_next.last   = 1'b1;
                    if (error_reg == ST_OK) begin
                        out_next.new_size    = next_new_rank_reg;
                        out_next.my_included = my_seen_reg;
                        out_next.my_new_rank = my_seen_reg ? my_new_value_reg : '0;
                    end
                    m_valid_next       = 1'b1;
                    next_new_rank_next = '0;
                    error_next         = ST_OK;
                    my_seen_next       = 1'b0;
                    my_new_value_next  = '0;
                    sweep_idx_next     = '0;
                    state_next         = S_SWEEP;
                end
            end

            default: begin
                state_next = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_SWEEP;
            sweep_idx_reg     <= '0;
            pend_valid_reg    <= 1'b0;
            next_new_rank_reg <= '0;
            error_reg         <= ST_OK;
            my_seen_reg       <= 1'b0;
            my_new_value_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            sweep_idx_reg     <= sweep_idx_next;
            pend_valid_reg    <= pend_valid_next;
            next_new_rank_reg <= next_new_rank_next;
            error_reg         <= error_next;
            my_seen_reg       <= my_seen_next;
            my_new_value_reg  <= my_new_value_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // walk and output payload, no reset needed
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        end_rank_reg <= end_rank_next;
        stride_reg   <= stride_next;
        single_reg   <= single_next;
        asc_reg      <= asc_next;
        fin_reg      <= fin_next;
        pend_new_reg <= pend_new_next;
        pend_old_reg <= pend_old_next;
        out_reg      <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_new_rank    = out_reg.new_rank;
    assign m_old_rank    = out_reg.old_rank;
    assign m_status      = out_reg.status;
    assign m_new_size    = out_reg.new_size;
    assign m_my_included = out_reg.my_included;
    assign m_my_new_rank = out_reg.my_new_rank;
    assign m_last        = out_reg.last;

    // assertions --------------------------------------------------------

    // no entry may be left behind when a new triplet is taken
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("entry still held back while accepting a triplet");

    // an error summary carries no size or placement
    a_err_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == KIND_SUMMARY) && (m_status != ST_OK))
            |-> ((m_new_size == '0) && !m_my_included && (m_my_new_rank == '0)))
        else $error("error summary with nonzero size fields");

    // each old rank is taken at most once per operation
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_new_rank_reg <= MAX_EFF)
        else $error("more new ranks than old ranks");

    // a summary is always followed by a fresh clearing pass with counters reset
    a_summary_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_SUMMARY) && slot_free)
            |=> ((state_reg == S_SWEEP) && (sweep_idx_reg == '0)
                 && (next_new_rank_reg == '0) && (error_reg == ST_OK)))
        else $error("operation state not cleared after summary");

endmodule

/* tb/sv/tb_strided_range_rank_select.sv */
`timescale 1ns / 1ps

module tb_strided_range_rank_select;
    import srrs_pkg::*;

    localparam int MAX_RANKS      = 32;
    // pause before a register write or the end: summary plus the clearing pass
    localparam int DRAIN_CYCLES   = MAX_RANKS + 16;
    // cycles with no handshake on either channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 400;
    localparam int PHASE_ITEMS    = 50;

    typedef struct packed {
        logic signed [7:0] start_rank;
        logic signed [7:0] stop_rank;
        logic signed [7:0] stride;
        logic              last_triplet;
    } triplet_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // register port
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // triplet channel
    logic              s_valid     = 1'b0;
    logic              s_ready;
    triplet_t          cur_triplet = '0;

    // result channel
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_kind;
    logic [RANK_W-1:0]   m_new_rank;
    logic [RANK_W-1:0]   m_old_rank;
    logic [STATUS_W-1:0] m_status;
    logic [SIZE_W-1:0]   m_new_size;
    logic                m_my_included;
    logic [RANK_W-1:0]   m_my_new_rank;
    logic                m_last;

    strided_range_rank_select #(
        .MAX_RANKS(MAX_RANKS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_rank  (cur_triplet.start_rank),
        .s_stop_rank   (cur_triplet.stop_rank),
        .s_stride      (cur_triplet.stride),
        .s_last_triplet(cur_triplet.last_triplet),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_new_rank    (m_new_rank),
        .m_old_rank    (m_old_rank),
        .m_status      (m_status),
        .m_new_size    (m_new_size),
        .m_my_included (m_my_included),
        .m_my_new_rank (m_my_new_rank),
        .m_last        (m_last)
    );

    // register copies held by the testbench
    logic [SIZE_W-1:0]   grp_size = 6'd32;
    logic [RANK_W-1:0]   own_rank = '0;

    // selection state of the operation in progress
    logic [31:0]         used_ranks    = '0;
    logic [SIZE_W-1:0]   new_count     = '0;
    logic [STATUS_W-1:0] op_status     = ST_OK;
    logic                mine_hit      = 1'b0;
    logic [RANK_W-1:0]   mine_new_rank = '0;

    triplet_t    triplets_to_send[$];
    result_t     due_words[$];
    int unsigned fail_count    = 0;
    int unsigned quiet_cycles  = 0;
    logic        triplet_taken = 1'b0;
    int unsigned send_gap      = 0;
    int unsigned recv_stall    = 0;
    logic [15:0] tick          = '0;

    // one quarter of the time both sides run without idling
    wire calm = (tick[9:8] == 2'b00);

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string word_text(result_t w);
        return $sformatf("kind=%0d new=%0d old=%0d status=%0d size=%0d incl=%0d my_new=%0d last=%0d",
                         w.kind, w.new_rank, w.old_rank, w.status, w.new_size,
                         w.my_included, w.my_new_rank, w.last);
    endfunction

    // walk one accepted triplet and queue the words it should produce
    function automatic void expand_triplet(triplet_t t);
        int      eff;
        int      fr;
        int      lr;
        int      st;
        int      idx;
        result_t w;
        result_t item_words[$];
        eff = (grp_size < MAX_RANKS) ? int'(grp_size) : MAX_RANKS;
        fr  = $signed(t.start_rank);
        lr  = $signed(t.stop_rank);
        st  = $signed(t.stride);

        // checks only run while no error is pending in this operation
        if (op_status == ST_OK) begin
            if (fr < 0 || fr >= eff || lr < 0 || lr >= eff)
                op_status = ST_RANGE;
            else if (st == 0)
                op_status = ST_ZERO_STEP;
            else if ((fr < lr && st < 0) || (fr > lr && st > 0))
                op_status = ST_SIGN;
            else begin
                idx = fr;
                while (1'b1) begin
                    if ((fr <= lr) ? (idx > lr) : (idx < lr))
                        break;
                    if (idx < 0 || idx >= eff)
                        break;
                    // already taken: words sent so far stand, selection stops
                    if (used_ranks[idx]) begin
                        op_status = ST_DUP;
                        break;
                    end
                    used_ranks[idx] = 1'b1;
                    if (idx == int'(own_rank)) begin
                        mine_hit      = 1'b1;
                        mine_new_rank = new_count[RANK_W-1:0];
                    end
                    w          = '0;
                    w.kind     = KIND_ENTRY;
                    w.new_rank = new_count[RANK_W-1:0];
                    w.old_rank = idx[RANK_W-1:0];
                    item_words.push_back(w);
                    new_count = new_count + 1'b1;
                    // a single-rank triplet stops whatever the stride
                    if (fr == lr)
                        break;
                    idx += st;
                end
            end
        end

        if (t.last_triplet) begin
            w      = '0;
            w.kind = KIND_SUMMARY;
            if (op_status != ST_OK)
                w.status = op_status;
            else begin
                w.status      = ST_OK;
                w.new_size    = new_count;
                w.my_included = mine_hit;
                w.my_new_rank = mine_hit ? mine_new_rank : '0;
            end
            item_words.push_back(w);
            used_ranks    = '0;
            new_count     = '0;
            op_status     = ST_OK;
            mine_hit      = 1'b0;
            mine_new_rank = '0;
        end

        if (item_words.size() != 0)
            item_words[item_words.size() - 1].last = 1'b1;
        foreach (item_words[i])
            due_words.push_back(item_words[i]);
    endfunction

    // triplet driver, changes on the falling edge
    always @(negedge aclk) begin : send_triplets
        logic     next_valid;
        triplet_t next_word;
        next_valid = s_valid && !triplet_taken;
        next_word  = cur_triplet;
        if (s_valid && triplet_taken)
            send_gap = calm ? 0 : pick_gap();
        if (!next_valid) begin
            if (send_gap != 0)
                send_gap--;
            else if (triplets_to_send.size() != 0) begin
                next_word  = triplets_to_send.pop_front();
                next_valid = 1'b1;
            end
        end
        s_valid     <= next_valid;
        cur_triplet <= next_word;
    end

    // result side back-pressure
    always @(negedge aclk) begin : stall_results
        tick <= tick + 1'b1;
        if (recv_stall != 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                recv_stall = pick_gap();
        end
    end

    // monitor: predict on each accepted triplet, check each accepted result word
    always @(posedge aclk) begin : watch_channels
        result_t got;
        result_t want;
        triplet_taken = aresetn && s_valid && s_ready;
        if (triplet_taken)
            expand_triplet(cur_triplet);

        if (aresetn && m_valid && m_ready) begin
            got = {m_kind, m_new_rank, m_old_rank, m_status, m_new_size,
                   m_my_included, m_my_new_rank, m_last};
            if (due_words.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word at %0t: %s", $time, word_text(got));
            end else begin
                want = due_words.pop_front();
                if (got.kind !== want.kind || got.new_rank !== want.new_rank ||
                    got.old_rank !== want.old_rank || got.status !== want.status ||
                    got.new_size !== want.new_size ||
                    got.my_included !== want.my_included ||
                    got.my_new_rank !== want.my_new_rank || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("result mismatch at %0t", $time);
                        $display("  expected %s", word_text(want));
                        $display("  actual   %s", word_text(got));
                    end
                end
            end
        end

        // watchdog over both channels
        if (triplet_taken || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("strided_range_rank_select test failed");
            $finish;
        end
    end

    // one apb transfer: setup, then access until pready
    task automatic apb_access(input logic wr, input logic idx, input logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_reg(input logic idx, input logic [APB_DW-1:0] want,
                              input logic [APB_DW-1:0] mask);
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if ((rd & mask) !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("register %0d read back %0h, expected %0h", idx, rd & mask, want);
        end
    endtask

    // write both registers with junk in the unused upper bits, then read back
    task automatic write_cfg(input logic [SIZE_W-1:0] size_val,
                             input logic [RANK_W-1:0] rank_val);
        logic [APB_DW-1:0] wdata;
        logic [APB_DW-1:0] unused;
        wdata               = $urandom;
        wdata[SIZE_W-1:0]   = size_val;
        apb_access(1'b1, REG_GROUP_SIZE, wdata, unused);
        wdata               = $urandom;
        wdata[RANK_W-1:0]   = rank_val;
        apb_access(1'b1, REG_MY_RANK, wdata, unused);
        grp_size = size_val;
        own_rank = rank_val;
        verify_reg(REG_GROUP_SIZE, APB_DW'(size_val), APB_DW'({SIZE_W{1'b1}}));
        verify_reg(REG_MY_RANK, APB_DW'(rank_val), APB_DW'({RANK_W{1'b1}}));
    endtask

    task automatic add_triplet(input int f, input int l, input int s, input logic fin);
        triplet_t t;
        t.start_rank   = f[7:0];
        t.stop_rank    = l[7:0];
        t.stride       = s[7:0];
        t.last_triplet = fin;
        triplets_to_send.push_back(t);
    endtask

    // everything sent and answered, then room for the clearing pass
    task automatic wait_idle();
        while (triplets_to_send.size() != 0 || s_valid || due_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int unsigned sent_count;
        int unsigned phase_items;
        int          eff;
        int          gs;
        int          rk;
        int          op_kind;
        int          op_len;
        int          span;
        int          lo;
        int          hi;
        int          f;
        int          l;
        int          s;
        int          m;
        int          r;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: full group both ways, every error, sticky error
        write_cfg(6'd32, 5'd0);
        add_triplet(0, 31, 1, 1'b0);
        add_triplet(0, 0, 1, 1'b1);          // duplicate on first rank
        add_triplet(31, 0, -1, 1'b1);        // whole group, my_rank lands last
        add_triplet(-128, 5, 1, 1'b1);       // negative first
        add_triplet(5, 127, 1, 1'b1);        // last far out
        add_triplet(32, 0, -1, 1'b1);        // rank equal to group size
        add_triplet(3, 9, 0, 1'b1);          // zero stride
        add_triplet(3, 9, -2, 1'b1);         // stride points away
        add_triplet(9, 3, 2, 1'b1);
        add_triplet(7, 7, -128, 1'b0);       // single rank, any stride
        add_triplet(0, 0, 127, 1'b1);
        add_triplet(8, 8, 0, 1'b0);          // zero stride beats single rank
        add_triplet(1, 30, 127, 1'b1);       // ignored after the error
        add_triplet(4, 10, 3, 1'b0);
        add_triplet(1, 31, 3, 1'b1);         // duplicate mid walk
        add_triplet(2, 20, 127, 1'b1);       // stride overshoots last
        add_triplet(-1, -1, -1, 1'b1);
        add_triplet(127, -128, -128, 1'b1);
        wait_idle();

        // empty group: nothing is in range
        write_cfg(6'd0, 5'd31);
        add_triplet(0, 0, 1, 1'b1);
        wait_idle();

        // my_rank outside a one-rank group
        write_cfg(6'd1, 5'd31);
        add_triplet(0, 0, 1, 1'b1);
        wait_idle();

        // group size beyond the rank limit is clipped
        write_cfg(6'd63, 5'd31);
        add_triplet(31, 0, -31, 1'b1);
        add_triplet(32, 32, 1, 1'b1);
        wait_idle();

        // random phases, each under a fresh register setting
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                gs = $urandom_range(33, 63);
            else if (r == 1)
                gs = 32;
            else if (r == 2)
                gs = 1;
            else
                gs = $urandom_range(2, 32);
            rk = $urandom_range(0, 31);
            write_cfg(gs[SIZE_W-1:0], rk[RANK_W-1:0]);
            eff = (gs < MAX_RANKS) ? gs : MAX_RANKS;

            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                op_kind = $urandom_range(0, 9);
                op_len  = $urandom_range(1, 4);
                if (op_kind < 4) begin
                    // disjoint runs covering the low ranks, status stays ok
                    span = $urandom_range(1, eff);
                    lo   = 0;
                    while (lo < span) begin
                        hi = lo + $urandom_range(0, (span - lo - 1 < 7) ? span - lo - 1 : 7);
                        if ($urandom_range(0, 1))
                            add_triplet(lo, hi, 1, hi == span - 1);
                        else
                            add_triplet(hi, lo, -1, hi == span - 1);
                        phase_items++;
                        lo = hi + 1;
                    end
                end else begin
                    for (int k = 0; k < op_len; k++) begin
                        if (op_kind < 8 || $urandom_range(0, 1)) begin
                            // in-range triplet, stride mostly small
                            f = $urandom_range(0, eff - 1);
                            l = $urandom_range(0, eff - 1);
                            r = $urandom_range(0, 9);
                            if (r < 7)
                                m = $urandom_range(1, 3);
                            else if (r < 9)
                                m = $urandom_range(1, eff);
                            else
                                m = $urandom_range(1, 128);
                            if (f == l)
                                s = $urandom_range(0, 1) ? m : -m;
                            else
                                s = (l > f) ? m : -m;
                            if (s > 127)
                                s = 127;
                            // now and then a stride of the wrong sign
                            if ($urandom_range(0, 9) == 0)
                                s = -s;
                        end else begin
                            f = $urandom_range(0, 255);
                            l = $urandom_range(0, 255);
                            s = $urandom_range(0, 255);
                        end
                        add_triplet(f, l, s, k == op_len - 1);
                        phase_items++;
                    end
                end
            end
            sent_count += phase_items;
            wait_idle();
        end

        if (fail_count == 0)
            $display("strided_range_rank_select test passed");
        else
            $display("strided_range_rank_select test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/srrs_pkg.sv
rtl/strided_range_rank_select.sv
tb/sv/tb_strided_range_rank_select.sv
